FILE: hw/rtl/fba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and controller/datapath interface types of the
// frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int DEF_NUM_FRAMES = 4096;
  localparam int MAX_RUN        = 16;
  localparam int RESULT_CAP     = 16;
  localparam int WORD_BITS      = 8 * 4;
  localparam int FRAME_SHIFT    = 12;
  localparam int RUN_W          = 5;
  localparam logic [31:0] PAGE_STEP = 32'h0000_1000;

  typedef enum logic [1:0] {
    CMD_ALLOC_ONE = 2'd0,
    CMD_ALLOC_RUN = 2'd1,
    CMD_FREE      = 2'd2,
    CMD_RESERVE   = 2'd3
  } fba_op_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_SKIPPED      = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } fba_status_t;

  // Kind of result the controller asks the datapath to build.
  typedef enum logic [2:0] {
    RES_ALLOC,
    RES_NO_FREE,
    RES_SKIP,
    RES_OUT_OF_RANGE,
    RES_MARKED
  } fba_res_t;

  typedef struct packed {
    logic     capture;
    logic     clr_wr;
    logic     rd_hint;
    logic     rd_next;
    logic     scan_hit;
    logic     scan_miss;
    logic     rd_tgt;
    logic     wr_tgt;
    logic     load_out;
    logic     advance_run;
    fba_res_t kind;
  } fba_ctl_t;

  typedef struct packed {
    fba_op_t op;
    logic    clear_last;
    logic    faddr_zero;
    logic    frame_oor;
    logic    run_zero;
    logic    full;
    logic    word_free;
    logic    ptr_last;
    logic    more_run;
    logic    out_free;
  } fba_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/frame_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit allocator of 4 KiB physical frames over a used-frame bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: alloc_one,
//   alloc_run, free or reserve. Output channel (out_valid / out_stall)
//   returns one result item per command, or one per page tried for alloc_run;
//   last marks the final result of a command.
//   One command is in flight at a time; in_stall is high from acceptance
//   until the final result is loaded into the output register.
//   Steps: free/reserve go through decode, read, write and emit; alloc_one
//   goes through decode, search, a scan of W bitmap words from the free-word
//   hint (usually 1) and emit; each further page of a run repeats search, scan, emit.
//   The scan reads one 32-bit word per cycle from the bitmap RAM port.
//   Reset: a clearing pass writes every bitmap word to zero, one word per
//   cycle; items wait during it.
//   Stall: a stalled result holds in the output register and the sequencer
//   waits before loading the next one; nothing is dropped.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::DEF_NUM_FRAMES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] virtual_page,
  input  wire logic [23:0] frame_address,
  input  wire logic [1:0]  old_perm,
  input  wire logic        writeable,
  input  wire logic        executable,
  input  wire logic [4:0]  run_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [23:0]      frame_out,
  output logic [31:0]      page_out,
  output logic [1:0]       perm_out,
  output logic             map_request,
  output logic             unmap_request,
  output logic             last
);
  import fba_pkg::*;

  fba_ctl_t  ctl;
  fba_stat_t stat;

  // Sequencer: steps each command through decode, scan or read-modify-write, and hand-off.
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath: bitmap RAM, hint, encoder and output register.
  fba_dpath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (cmd),
    .virtual_page  (virtual_page),
    .frame_address (frame_address),
    .old_perm      (old_perm),
    .writeable     (writeable),
    .executable    (executable),
    .run_length    (run_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .frame_out     (frame_out),
    .page_out      (page_out),
    .perm_out      (perm_out),
    .map_request   (map_request),
    .unmap_request (unmap_request),
    .last          (last)
  );

  // Hold off new items for the cycle after one is taken.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("item accepted while previous item still in progress");

  // Clearing pass never shares the RAM write port with a scan or update.
  a_clear_exclusive: assert property (
    @(posedge clk) disable iff (rst)
    ctl.clr_wr |-> !(ctl.scan_hit || ctl.wr_tgt || ctl.load_out)
  ) else $error("bitmap write collision during clearing pass");

  // Only successful run allocations may be followed by more results.
  a_non_last_is_alloc: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (map_request && status == ST_DONE)
  ) else $error("non-final result that is not a successful allocation");

endmodule
`default_nettype wire

FILE: hw/rtl/fba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl
// Command sequencer: clearing pass, decode, bitmap scan, read-modify-write
// of a target word and result hand-off.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fba_pkg::fba_stat_t stat,
  output fba_pkg::fba_ctl_t       ctl
);
  import fba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SCAN,
    S_READ_TGT,
    S_MODIFY,
    S_EMIT
  } state_t;

  state_t   state, state_next;
  fba_res_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind  <= RES_SKIP;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    ctl             = '0;
    ctl.kind        = kind;
    case (state)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          CMD_ALLOC_ONE: begin
            if (!stat.faddr_zero) begin
              kind_next  = RES_SKIP;
              state_next = S_EMIT;
            end else begin
              state_next = S_SEARCH;
            end
          end
          CMD_ALLOC_RUN: begin
            if (stat.run_zero) begin
              kind_next  = RES_SKIP;
              state_next = S_EMIT;
            end else begin
              state_next = S_SEARCH;
            end
          end
          default: begin
            if (stat.op == CMD_FREE && stat.faddr_zero) begin
              kind_next  = RES_SKIP;
              state_next = S_EMIT;
            end else if (stat.frame_oor) begin
              kind_next  = RES_OUT_OF_RANGE;
              state_next = S_EMIT;
            end else begin
              state_next = S_READ_TGT;
            end
          end
        endcase
      end
      S_SEARCH: begin
        if (stat.full) begin
          kind_next  = RES_NO_FREE;
          state_next = S_EMIT;
        end else begin
          ctl.rd_hint = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.word_free) begin
          ctl.scan_hit = 1'b1;
          kind_next    = RES_ALLOC;
          state_next   = S_EMIT;
        end else if (stat.ptr_last) begin
          ctl.scan_miss = 1'b1;
          kind_next     = RES_NO_FREE;
          state_next    = S_EMIT;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      S_READ_TGT: begin
        ctl.rd_tgt = 1'b1;
        state_next = S_MODIFY;
      end
      S_MODIFY: begin
        ctl.wr_tgt = 1'b1;
        kind_next  = RES_MARKED;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          if (kind == RES_ALLOC && stat.more_run) begin
            ctl.advance_run = 1'b1;
            state_next      = S_SEARCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/fba_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_dpath
// Bitmap RAM, scan pointer and free-word hint, lowest-zero encoder, item
// registers and the output register.
// ----------------------------------------------------------------------------
module fba_dpath #(
  parameter int NUM_FRAMES = fba_pkg::DEF_NUM_FRAMES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fba_pkg::fba_ctl_t  ctl,
  output fba_pkg::fba_stat_t      stat,
  input  wire logic [1:0]         cmd,
  input  wire logic [31:0]        virtual_page,
  input  wire logic [23:0]        frame_address,
  input  wire logic [1:0]         old_perm,
  input  wire logic               writeable,
  input  wire logic               executable,
  input  wire logic [4:0]         run_length,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [23:0]             frame_out,
  output logic [31:0]             page_out,
  output logic [1:0]              perm_out,
  output logic                    map_request,
  output logic                    unmap_request,
  output logic                    last
);
  import fba_pkg::*;

  localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int HINT_W    = $clog2(NUM_WORDS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int LAST_BITS = NUM_FRAMES - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
  localparam int RUN_CAP   = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;

  // Item registers
  fba_op_t          op;
  logic [31:0]      page;
  logic [23:0]      faddr;
  logic [1:0]       operm;
  logic [1:0]       addbits;
  logic [RUN_W-1:0] remain;

  // Scan state
  logic [HINT_W-1:0] hint;
  logic [WI_W-1:0]   ptr;
  logic [WI_W-1:0]   clr_cnt;
  logic [23:0]       found_addr;

  // RAM port
  logic                 ram_we, ram_re;
  logic [WI_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rdata;

  logic [11:0]          fnum;
  logic [31:0]          fnum_ext;
  logic [WI_W-1:0]      tgt_word;
  logic [BIT_W-1:0]     tgt_bit;
  logic [WORD_BITS-1:0] tgt_onehot;
  logic [WORD_BITS-1:0] word_mask, free_vec, hit_onehot;
  logic [BIT_W-1:0]     hit_bit;
  logic [31:0]          hit_frame;
  logic                 ptr_last;

  assign fnum       = faddr[23:FRAME_SHIFT];
  assign fnum_ext   = 32'(fnum);
  assign tgt_word   = fnum_ext[BIT_W +: WI_W];
  assign tgt_bit    = fnum[BIT_W-1:0];
  assign tgt_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << tgt_bit;
  assign ptr_last   = (ptr == WI_W'(NUM_WORDS - 1));

  // Bits past the last frame count as used.
  assign word_mask = ptr_last ? LAST_MASK : {WORD_BITS{1'b1}};
  assign free_vec  = ~rdata & word_mask;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) hit_bit = BIT_W'(i);
    end
  end

  assign hit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << hit_bit;
  assign hit_frame  = (32'(ptr) << BIT_W) | 32'(hit_bit);

  always_comb begin
    ram_we    = ctl.clr_wr | ctl.scan_hit | ctl.wr_tgt;
    ram_waddr = tgt_word;
    ram_wdata = (op == CMD_FREE) ? (rdata & ~tgt_onehot) : (rdata | tgt_onehot);
    if (ctl.clr_wr) begin
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (ctl.scan_hit) begin
      ram_waddr = ptr;
      ram_wdata = rdata | hit_onehot;
    end
    ram_re    = ctl.rd_hint | ctl.rd_next | ctl.rd_tgt;
    ram_raddr = tgt_word;
    if (ctl.rd_hint) begin
      ram_raddr = hint[WI_W-1:0];
    end else if (ctl.rd_next) begin
      ram_raddr = ptr + 1'b1;
    end
  end

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS),
    .AW    (WI_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Control registers: clear counter, hint, scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hint    <= '0;
      ptr     <= '0;
    end else begin
      if (ctl.clr_wr) clr_cnt <= clr_cnt + 1'b1;
      if (ctl.rd_hint) begin
        ptr <= hint[WI_W-1:0];
      end else if (ctl.rd_next) begin
        ptr <= ptr + 1'b1;
      end
      // Words below the hint are known full.
      if (ctl.scan_hit) begin
        hint <= HINT_W'(ptr);
      end else if (ctl.scan_miss) begin
        hint <= HINT_W'(NUM_WORDS);
      end else if (ctl.wr_tgt && op == CMD_FREE && HINT_W'(tgt_word) < hint) begin
        hint <= HINT_W'(tgt_word);
      end
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op      <= fba_op_t'(cmd);
      page    <= virtual_page;
      faddr   <= frame_address;
      operm   <= old_perm;
      addbits <= {writeable, executable};
      if (fba_op_t'(cmd) == CMD_ALLOC_RUN) begin
        remain <= (run_length > RUN_W'(RUN_CAP)) ? RUN_W'(RUN_CAP) : run_length;
      end else begin
        remain <= RUN_W'(1);
      end
    end else if (ctl.advance_run) begin
      remain <= remain - 1'b1;
      page   <= page + PAGE_STEP;
    end
    if (ctl.scan_hit) begin
      found_addr <= {hit_frame[11:0], 12'h000};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      page_out      <= page;
      map_request   <= 1'b0;
      unmap_request <= 1'b0;
      last          <= (ctl.kind != RES_ALLOC) || (remain == RUN_W'(1));
      case (ctl.kind)
        RES_ALLOC: begin
          status      <= ST_DONE;
          frame_out   <= found_addr;
          perm_out    <= operm | addbits;
          map_request <= 1'b1;
        end
        RES_NO_FREE: begin
          status    <= ST_NO_FREE;
          frame_out <= '0;
          perm_out  <= operm;
        end
        RES_SKIP: begin
          status    <= ST_SKIPPED;
          frame_out <= (op == CMD_ALLOC_RUN) ? 24'h0 : faddr;
          perm_out  <= (op == CMD_FREE) ? 2'b00 : operm;
        end
        RES_OUT_OF_RANGE: begin
          status    <= ST_OUT_OF_RANGE;
          frame_out <= faddr;
          perm_out  <= 2'b00;
        end
        default: begin
          status        <= ST_DONE;
          frame_out     <= faddr;
          perm_out      <= 2'b00;
          unmap_request <= (op == CMD_FREE);
        end
      endcase
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = op;
    stat.clear_last = (clr_cnt == WI_W'(NUM_WORDS - 1));
    stat.faddr_zero = (faddr == 24'h0);
    stat.frame_oor  = (fnum_ext >= 32'(NUM_FRAMES));
    stat.run_zero   = (remain == '0);
    stat.full       = (hint == HINT_W'(NUM_WORDS));
    stat.word_free  = |free_vec;
    stat.ptr_last   = ptr_last;
    stat.more_run   = (remain > RUN_W'(1));
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire
